/* src/atblpd_pkg.sv */
// ----------------------------------------------------------------------------
// atblpd_pkg
// Shared kind codes and stage types for the branch/literal predecoder.
// ----------------------------------------------------------------------------
package atblpd_pkg;

   localparam logic [1:0] T16_NONE    = 2'd0;
   localparam logic [1:0] T16_BRANCH  = 2'd1;
   localparam logic [1:0] T16_LITERAL = 2'd2;

   localparam logic [1:0] T32_NONE = 2'd0;
   localparam logic [1:0] T32_BL   = 2'd1;
   localparam logic [1:0] T32_BLX  = 2'd2;

   localparam logic [2:0] ARM_NONE       = 3'd0;
   localparam logic [2:0] ARM_BRANCH     = 3'd1;
   localparam logic [2:0] ARM_BLX        = 3'd2;
   localparam logic [2:0] ARM_LITERAL    = 3'd3;
   localparam logic [2:0] ARM_LITERAL_PC = 3'd4;

   // Decoded operands: target = base + offset (ARM may subtract).
   typedef struct packed {
      logic [1:0]  t16_kind;
      logic [31:0] t16_base;
      logic [31:0] t16_off;
      logic [1:0]  t32_kind;
      logic [31:0] t32_base;
      logic [31:0] t32_off;
      logic [2:0]  arm_kind;
      logic        arm_sub;
      logic [31:0] arm_base;
      logic [31:0] arm_off;
   } decode_type;

   // Summed targets, before final alignment and zeroing.
   typedef struct packed {
      logic [1:0]  t16_kind;
      logic [31:0] t16_sum;
      logic [1:0]  t32_kind;
      logic [31:0] t32_sum;
      logic [2:0]  arm_kind;
      logic [31:0] arm_sum;
   } sum_type;

endpackage

/* src/arm_thumb_branch_literal_predecode.sv */
// ----------------------------------------------------------------------------
// arm_thumb_branch_literal_predecode
// Three-stage predecoder of Thumb-16, Thumb-32 and ARM branch/literal targets.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one instruction address and four little-endian
//   instruction bytes per transfer. The rsp_ channel returns one result per
//   request: a kind and a target for each of the three views, in order.
//   rsp_valid rises once the request has passed the stage 1 and stage 2
//   registers into the output register. A new request can transfer every
//   cycle while responses are taken, so throughput is one item per cycle.
//   Stage 1 matches the opcode patterns and forms base and offset, stage 2
//   does the target add (one 32-bit adder per view), stage 3 aligns BLX
//   targets, zeroes targets of views that did not match, and is the output
//   register.
//   Each stage has a valid bit and advances when it is empty or the stage
//   after it advances; a stalled receiver holds the output and back-pressure
//   fills the pipe, so up to three items wait inside before req_ready drops.
//   Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module arm_thumb_branch_literal_predecode
   import atblpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr_address,
   input  logic [31:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_thumb16_kind,
   output logic [31:0] rsp_thumb16_target,
   output logic [1:0]  rsp_thumb32_kind,
   output logic [31:0] rsp_thumb32_target,
   output logic [2:0]  rsp_arm_kind,
   output logic [31:0] rsp_arm_target
);

   decode_type dec_in, dec_ff;
   sum_type    sum_in, sum_ff;
   logic       v1_ff, v2_ff, v3_ff;
   logic       adv1, adv2, adv3;

   logic [1:0]  t16_kind_ff, t32_kind_ff;
   logic [2:0]  arm_kind_ff;
   logic [31:0] t16_tgt_ff, t32_tgt_ff, arm_tgt_ff;
   logic [31:0] t16_tgt_in, t32_tgt_in, arm_tgt_in;

   // A stage advances when it is empty or its successor advances.
   assign adv3      = !v3_ff || rsp_ready;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;

   // Stage 1: pattern decode
   atblpd_decode u_decode (
      .instr_address (req_instr_address),
      .instr_word    (req_instr_word),
      .dec           (dec_in)
   );

   // Stage 2: target adds
   always_comb begin
      sum_in.t16_kind = dec_ff.t16_kind;
      sum_in.t16_sum  = dec_ff.t16_base + dec_ff.t16_off;
      sum_in.t32_kind = dec_ff.t32_kind;
      sum_in.t32_sum  = dec_ff.t32_base + dec_ff.t32_off;
      sum_in.arm_kind = dec_ff.arm_kind;
      // subtract as add of the inverted offset with carry in
      sum_in.arm_sum  = dec_ff.arm_base + (dec_ff.arm_off ^ {32{dec_ff.arm_sub}})
                      + {31'd0, dec_ff.arm_sub};
   end

   // Stage 3: align BLX, drop targets of views that did not match
   always_comb begin
      t16_tgt_in = (sum_ff.t16_kind == T16_NONE) ? 32'd0 : sum_ff.t16_sum;
      case (sum_ff.t32_kind)
         T32_BL:  t32_tgt_in = sum_ff.t32_sum;
         T32_BLX: t32_tgt_in = {sum_ff.t32_sum[31:2], 2'b00};
         default: t32_tgt_in = 32'd0;
      endcase
      arm_tgt_in = (sum_ff.arm_kind == ARM_NONE) ? 32'd0 : sum_ff.arm_sum;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   // Payload registers; hold while the stage stalls
   always_ff @(posedge clock) begin
      if (adv1) begin
         dec_ff <= dec_in;
      end
      if (adv2) begin
         sum_ff <= sum_in;
      end
      if (adv3) begin
         t16_kind_ff <= sum_ff.t16_kind;
         t16_tgt_ff  <= t16_tgt_in;
         t32_kind_ff <= sum_ff.t32_kind;
         t32_tgt_ff  <= t32_tgt_in;
         arm_kind_ff <= sum_ff.arm_kind;
         arm_tgt_ff  <= arm_tgt_in;
      end
   end

   assign rsp_valid          = v3_ff;
   assign rsp_thumb16_kind   = t16_kind_ff;
   assign rsp_thumb16_target = t16_tgt_ff;
   assign rsp_thumb32_kind   = t32_kind_ff;
   assign rsp_thumb32_target = t32_tgt_ff;
   assign rsp_arm_kind       = arm_kind_ff;
   assign rsp_arm_target     = arm_tgt_ff;

endmodule

/* src/atblpd_decode.sv */
// ----------------------------------------------------------------------------
// atblpd_decode
// Pattern match of the three views; produces kind, base and offset for each.
// ----------------------------------------------------------------------------
module atblpd_decode
   import atblpd_pkg::*;
(
   input  logic [31:0] instr_address,
   input  logic [31:0] instr_word,
   output decode_type  dec
);

   logic [15:0] first_hw;
   logic [15:0] second_hw;
   logic [31:0] addr_p4;
   logic [31:0] addr_p8;

   assign first_hw  = instr_word[15:0];
   assign second_hw = instr_word[31:16];
   assign addr_p4   = instr_address + 32'd4;
   assign addr_p8   = instr_address + 32'd8;

   always_comb begin
      dec = '0;

      // Thumb 16-bit view
      dec.t16_base = addr_p4;
      if (!instr_address[0]) begin
         if (first_hw[15:11] == 5'b11100) begin
            dec.t16_kind = T16_BRANCH;
            dec.t16_off  = {{20{first_hw[10]}}, first_hw[10:0], 1'b0};
         end else if (first_hw[15:12] == 4'b1101) begin
            dec.t16_kind = T16_BRANCH;
            dec.t16_off  = {{23{first_hw[7]}}, first_hw[7:0], 1'b0};
         end else if (first_hw[15:11] == 5'b01001) begin
            dec.t16_kind = T16_LITERAL;
            dec.t16_base = {addr_p4[31:2], 2'b00};
            dec.t16_off  = {22'd0, first_hw[7:0], 2'b00};
         end
      end

      // Thumb 32-bit view; the two offset fields do not overlap
      dec.t32_base = addr_p4;
      dec.t32_off  = {{9{first_hw[10]}}, first_hw[10:0], second_hw[10:0], 1'b0};
      if (!instr_address[0] && first_hw[15:11] == 5'b11110) begin
         if (second_hw[15:11] == 5'b11101) begin
            dec.t32_kind = T32_BLX;
         end else if (second_hw[15:11] == 5'b11111) begin
            dec.t32_kind = T32_BL;
         end
      end

      // ARM view
      dec.arm_base = addr_p8;
      if (instr_address[1:0] == 2'b00) begin
         if (instr_word[31:25] == 7'b1111101) begin
            dec.arm_kind = ARM_BLX;
            dec.arm_off  = {{6{instr_word[23]}}, instr_word[23:0], instr_word[24], 1'b0};
         end else if (instr_word[27:25] == 3'b101) begin
            dec.arm_kind = ARM_BRANCH;
            dec.arm_off  = {{6{instr_word[23]}}, instr_word[23:0], 2'b00};
         end else if (instr_word[27:25] == 3'b010 && instr_word[19:16] == 4'hF) begin
            dec.arm_kind = (instr_word[15:12] == 4'hF) ? ARM_LITERAL_PC : ARM_LITERAL;
            dec.arm_sub  = !instr_word[23];
            dec.arm_off  = {20'd0, instr_word[11:0]};
         end
      end
   end

endmodule
